// ----- hdl/asc_pkg.sv -----
// Shared types, widths and codes for the aliquot sum classifier.
// Used by every other file under hdl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

    // Width of the number as used inside the block (8..32).
    localparam int NUMBER_BITS  = 16;
    // Fixed field widths of the words on the channels.
    localparam int IN_BITS      = 16;
    localparam int SUM_BITS     = 18;
    localparam int CLASS_BITS   = 2;
    // Internal sum: sigma(n) - n stays below 8 * n for n < 2^32.
    localparam int SUM_INT_BITS = (NUMBER_BITS + 3 > SUM_BITS + 1) ?
                                  NUMBER_BITS + 3 : SUM_BITS + 1;
    // Step counter of the remainder unit holds NUMBER_BITS itself.
    localparam int CNT_BITS     = $clog2(NUMBER_BITS + 1);

    localparam int FIRST_CANDIDATE = 2;

    typedef logic [NUMBER_BITS-1:0]  t_num;
    typedef logic [SUM_INT_BITS-1:0] t_sum_int;
    typedef logic [SUM_BITS-1:0]     t_sum;
    typedef logic [CLASS_BITS-1:0]   t_class;
    typedef logic [CNT_BITS-1:0]     t_cnt;

    localparam t_sum   SUM_MAX         = '1;

    localparam t_class CLASS_DEFICIENT = 2'd0;
    localparam t_class CLASS_PERFECT   = 2'd1;
    localparam t_class CLASS_ABUNDANT  = 2'd2;

    // Request to the remainder unit.
    typedef struct packed {
        logic start;
        t_num dividend;
        t_num divisor;
    } t_div_req;

    // Status back from the remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
        t_num rem;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- hdl/asc_if.sv -----
// Valid/ready channel interfaces for the aliquot sum classifier.
// Depends on asc_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface asc_in_if;
    logic                          valid;
    logic                          ready;
    logic [asc_pkg::IN_BITS-1:0]   number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface asc_out_if;
    logic                          valid;
    logic                          ready;
    logic [asc_pkg::SUM_BITS-1:0]  divisor_sum;
    logic [asc_pkg::CLASS_BITS-1:0] number_class;

    modport source (output valid, output divisor_sum, output number_class, input ready);
    modport sink   (input valid, input divisor_sum, input number_class, output ready);
endinterface

`default_nettype wire

// ----- hdl/asc_div.sv -----
// Shared restoring remainder unit: one quotient bit per cycle.
// Depends on asc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asc_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  asc_pkg::t_div_req  i_req,
    output asc_pkg::t_div_stat o_stat
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    asc_pkg::t_cnt                r_cnt, n_cnt;
    asc_pkg::t_num                r_rem, n_rem;
    asc_pkg::t_num                r_q, n_q;

    logic [asc_pkg::NUMBER_BITS:0] rem_sh;
    logic [asc_pkg::NUMBER_BITS:0] rem_diff;

    always_comb begin
        rem_sh   = {r_rem, r_q[asc_pkg::NUMBER_BITS-1]};
        rem_diff = rem_sh - {1'b0, i_req.divisor};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = asc_pkg::t_cnt'(asc_pkg::NUMBER_BITS);
            n_rem  = '0;
            n_q    = i_req.dividend;
        end else if (r_busy) begin
            // restore unless the shifted remainder covers the divisor
            if (!rem_diff[asc_pkg::NUMBER_BITS]) begin
                n_rem = rem_diff[asc_pkg::NUMBER_BITS-1:0];
            end else begin
                n_rem = rem_sh[asc_pkg::NUMBER_BITS-1:0];
            end
            n_q   = {r_q[asc_pkg::NUMBER_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == asc_pkg::t_cnt'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

`default_nettype wire

// ----- hdl/aliquot_sum_classifier_core.sv -----
// Aliquot sum classifier: sequencer, divisor sum and output word register.
// Depends on asc_pkg, asc_in_if / asc_out_if and asc_div.
//
// Usage:
//   i_in  takes one word: number (16 bits, low NUMBER_BITS used).
//   o_out gives one word per input: divisor_sum (sum of proper divisors,
//   saturated at 18 bits) and number_class (0 deficient, 1 perfect,
//   2 abundant). Zero and one give sum 0, deficient.
// Operation:
//   Every candidate d from 2 to n/2 goes through the shared remainder
//   unit, which retires one bit per cycle, so run time grows with n;
//   n < 4 skips the unit. A new word is taken only once the last one's
//   result has been written to the output register.
//   i_in.ready is high only while the sequencer is idle.
// Stall:
//   A finished word sits in the output register until taken; a new input
//   is accepted meanwhile, and its result waits in the classify state if
//   the output register is still full.
// Reset:
//   Synchronous, active low; clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module aliquot_sum_classifier_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    asc_in_if.sink     i_in,
    asc_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_CLASSIFY
    } t_state;

    t_state               r_state, n_state;
    asc_pkg::t_num        r_num, n_num;
    asc_pkg::t_num        r_half, n_half;
    asc_pkg::t_num        r_cand, n_cand;
    asc_pkg::t_sum_int    r_sum, n_sum;
    logic                 r_out_valid, n_out_valid;
    asc_pkg::t_sum        r_out_sum, n_out_sum;
    asc_pkg::t_class      r_out_class, n_out_class;

    asc_pkg::t_div_req    div_req;
    asc_pkg::t_div_stat   div_stat;

    asc_pkg::t_num        in_num;
    asc_pkg::t_sum_int    num_ext;
    logic                 out_free;

    asc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    always_comb begin
        in_num           = asc_pkg::t_num'(i_in.number);
        num_ext          = asc_pkg::t_sum_int'(r_num);
        out_free         = !r_out_valid || o_out.ready;
        div_req.start    = (r_state == S_DIV_START);
        div_req.dividend = r_num;
        div_req.divisor  = r_cand;
    end

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_half      = r_half;
        n_cand      = r_cand;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_class = r_out_class;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_num  = in_num;
                    n_half = in_num >> 1;
                    n_cand = asc_pkg::t_num'(asc_pkg::FIRST_CANDIDATE);
                    if (in_num < asc_pkg::t_num'(2)) begin
                        n_sum   = '0;
                        n_state = S_CLASSIFY;
                    end else begin
                        n_sum = asc_pkg::t_sum_int'(1);
                        // n = 2 or 3: no candidate to try
                        if (in_num < asc_pkg::t_num'(4)) begin
                            n_state = S_CLASSIFY;
                        end else begin
                            n_state = S_DIV_START;
                        end
                    end
                end
            end
            S_DIV_START: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    if (div_stat.rem == '0) begin
                        n_sum = r_sum + asc_pkg::t_sum_int'(r_cand);
                    end
                    if (r_cand == r_half) begin
                        n_state = S_CLASSIFY;
                    end else begin
                        n_cand  = r_cand + 1'b1;
                        n_state = S_DIV_START;
                    end
                end
            end
            S_CLASSIFY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sum > asc_pkg::t_sum_int'(asc_pkg::SUM_MAX)) begin
                        n_out_sum = asc_pkg::SUM_MAX;
                    end else begin
                        n_out_sum = r_sum[asc_pkg::SUM_BITS-1:0];
                    end
                    // zero has sum 0 == n but is not perfect
                    priority if (r_num == '0 || r_sum < num_ext) begin
                        n_out_class = asc_pkg::CLASS_DEFICIENT;
                    end else if (r_sum == num_ext) begin
                        n_out_class = asc_pkg::CLASS_PERFECT;
                    end else begin
                        n_out_class = asc_pkg::CLASS_ABUNDANT;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_num       <= n_num;
        r_half      <= n_half;
        r_cand      <= n_cand;
        r_sum       <= n_sum;
        r_out_sum   <= n_out_sum;
        r_out_class <= n_out_class;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.divisor_sum  = r_out_sum;
    assign o_out.number_class = r_out_class;

endmodule

`default_nettype wire

// ----- hdl/asc_checker.sv -----
// Port-level checks for aliquot_sum_classifier_core, attached by bind.
// Depends on asc_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module asc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [asc_pkg::SUM_BITS-1:0]  i_out_sum,
    input wire [asc_pkg::CLASS_BITS-1:0] i_out_class
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_class == asc_pkg::CLASS_DEFICIENT ||
                         i_out_class == asc_pkg::CLASS_PERFECT ||
                         i_out_class == asc_pkg::CLASS_ABUNDANT))
        else $error("unused class code on output");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // smallest perfect number is 6
    a_perfect_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_class == asc_pkg::CLASS_PERFECT |->
            i_out_sum >= asc_pkg::SUM_BITS'(6))
        else $error("perfect class with too small a sum");

endmodule

bind aliquot_sum_classifier_core asc_checker u_asc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_sum   (o_out.divisor_sum),
    .i_out_class (o_out.number_class)
);

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for aliquot_sum_classifier_core: drives numbers on i_in and
// compares each o_out word against a local divisor-sum predictor.
// Depends on asc_pkg, asc_in_if / asc_out_if and the core RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        asc_pkg::t_sum   divisor_sum;
        asc_pkg::t_class number_class;
    } t_aliquot_word;

    localparam int RANDOM_ITEMS  = 81;
    localparam int HOLD_CYCLES   = 3000;
    localparam int HOLD_AFTER    = 40;
    localparam int DRAIN_CYCLES  = 20;

    logic i_clk;
    logic i_rst_n;

    asc_in_if  in_if ();
    asc_out_if out_if ();

    aliquot_sum_classifier_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [asc_pkg::IN_BITS-1:0] pending_numbers[$];
    t_aliquot_word               expected_words[$];

    int  items_total;
    int  items_sent;
    int  words_seen;
    int  mismatches;
    int  send_gap;
    int  take_gap;
    int  class_count[3];
    logic hold_off;

    // Reference divisor sum: trial division over 2..n/2, sum starts at 1.
    function automatic t_aliquot_word aliquot_predict(
        input logic [asc_pkg::IN_BITS-1:0] raw);
        longint unsigned n;
        longint unsigned total;
        longint unsigned d;
        t_aliquot_word   w;
        n = longint'(raw) & ((64'd1 << asc_pkg::NUMBER_BITS) - 1);
        total = 0;
        if (n >= 2) begin
            total = 1;
            for (d = asc_pkg::FIRST_CANDIDATE; d <= n / 2; d++) begin
                if (n % d == 0)
                    total += d;
            end
        end
        if (n == 0 || total < n)
            w.number_class = asc_pkg::CLASS_DEFICIENT;
        else if (total == n)
            w.number_class = asc_pkg::CLASS_PERFECT;
        else
            w.number_class = asc_pkg::CLASS_ABUNDANT;
        w.divisor_sum = (total > longint'(asc_pkg::SUM_MAX)) ? asc_pkg::SUM_MAX :
                        asc_pkg::t_sum'(total);
        return w;
    endfunction

    // Half the time no gap, often a short one, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(80, 20);
    endfunction

    // Keep most numbers small: run time grows with n.
    function automatic logic [asc_pkg::IN_BITS-1:0] random_number();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return asc_pkg::IN_BITS'($urandom_range(255));
        else if (r < 95)
            return asc_pkg::IN_BITS'($urandom_range(1023, 256));
        else
            return asc_pkg::IN_BITS'($urandom_range(4095, 1024));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH word %0d: %s", words_seen, msg);
        mismatches++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(60_000_000);
        $display("aliquot_sum_classifier_core regression: fail");
        $finish;
    end

    // Driver: one word offered at a time, held until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_words.insert(expected_words.size(),
                                      aliquot_predict(in_if.number));
                items_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (hold_off)
                    send_gap = 0;
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_numbers.size() > 0) begin
                    in_if.number <= pending_numbers.pop_front();
                    in_if.valid  <= 1'b1;
                    send_gap = idle_cycles();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken word, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        t_aliquot_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("no expected word waiting");
                end else begin
                    want = expected_words.pop_front();
                    if (out_if.divisor_sum !== want.divisor_sum)
                        report_mismatch($sformatf("divisor_sum expected %0d got %0d",
                                                  want.divisor_sum,
                                                  out_if.divisor_sum));
                    if (out_if.number_class !== want.number_class)
                        report_mismatch($sformatf("number_class expected %0d got %0d",
                                                  want.number_class,
                                                  out_if.number_class));
                    if (want.number_class <= asc_pkg::CLASS_ABUNDANT)
                        class_count[want.number_class]++;
                end
                words_seen++;
                take_gap = idle_cycles();
            end
            if (hold_off) begin
                out_if.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off: core fills its output register and stalls i_in.
    initial begin
        hold_off = 1'b0;
        while (words_seen < HOLD_AFTER)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.number = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        items_sent   = 0;
        words_seen   = 0;
        mismatches   = 0;
        class_count  = '{0, 0, 0};

        // Directed: zero, one, the short n < 4 path, primes, perfect numbers,
        // smallest even and odd abundant, powers of two, all ones.
        pending_numbers = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6,
                            16'd12, 16'd28, 16'd496, 16'd945, 16'd127, 16'd128,
                            16'd255, 16'd256, 16'd720, 16'd1021, 16'd1024,
                            16'hFFFF};
        repeat (RANDOM_ITEMS)
            pending_numbers.insert(pending_numbers.size(), random_number());
        items_total = pending_numbers.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_sent < items_total || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d numbers, %0d result words checked, %0d mismatches.",
                 items_sent, words_seen, mismatches);
        $display("Classes seen: %0d deficient, %0d perfect, %0d abundant.",
                 class_count[asc_pkg::CLASS_DEFICIENT],
                 class_count[asc_pkg::CLASS_PERFECT],
                 class_count[asc_pkg::CLASS_ABUNDANT]);
        if (mismatches == 0 && words_seen == items_total)
            $display("aliquot_sum_classifier_core regression: pass");
        else
            $display("aliquot_sum_classifier_core regression: fail");
        $finish;
    end

endmodule
